// ===== src/gtfq_pkg.sv =====
// Shared types and constants of the generation-tagged frame queue.
`default_nettype none

package gtfq_pkg;

    // Request operations
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_DEQUEUE = 2'd2,
        OP_CANCEL  = 2'd3
    } t_op;

    // Receipt outcomes
    typedef enum logic [2:0] {
        OC_CHANGED   = 3'd0,
        OC_NOOP      = 3'd1,
        OC_STALE     = 3'd2,
        OC_CANCELLED = 3'd3,
        OC_REFUSED   = 3'd4,
        OC_ERROR     = 3'd5
    } t_outcome;

    // Receipt reasons
    typedef enum logic [2:0] {
        RS_NONE          = 3'd0,
        RS_STALE_GEN     = 3'd1,
        RS_GEN_CANCELLED = 3'd2,
        RS_OP_CANCELLED  = 3'd3,
        RS_FRAME_CAP     = 3'd4,
        RS_BYTE_CAP      = 3'd5
    } t_reason;

    // Error codes
    typedef enum logic [2:0] {
        EC_NONE         = 3'd0,
        EC_BAD_GEN      = 3'd1,
        EC_NO_STAMP     = 3'd2,
        EC_BAD_BASE     = 3'd3,
        EC_BASE_CHANGED = 3'd4,
        EC_STAMP_ORDER  = 3'd5,
        EC_BAD_DIMS     = 3'd6,
        EC_REV_OVERFLOW = 3'd7
    } t_error;

    // Request transaction
    typedef struct packed {
        t_op                operation;
        logic        [31:0] generation;
        logic signed [47:0] timestamp;
        logic               has_timestamp;
        logic signed [31:0] rate_num;
        logic signed [31:0] rate_den;
        logic        [15:0] frame_width;
        logic        [15:0] frame_height;
        logic               cancel_requested;
    } t_req;

    // Receipt transaction
    typedef struct packed {
        t_outcome           outcome;
        t_reason            reason;
        t_error             error_code;
        logic        [31:0] current_generation;
        logic        [31:0] revision_now;
        logic        [4:0]  frame_count;
        logic        [39:0] byte_count;
        logic               frame_valid;
        logic signed [47:0] frame_timestamp;
        logic        [35:0] frame_bytes;
        logic        [30:0] out_rate_num;
        logic        [30:0] out_rate_den;
    } t_result;

    // One queued frame descriptor
    typedef struct packed {
        logic signed [47:0] stamp;
        logic        [35:0] size;
    } t_entry;

    // Configuration registers as seen by the engine
    typedef struct packed {
        logic [4:0]  max_frames;
        logic [39:0] max_bytes;
    } t_cfg;

    localparam int          PIXEL_SHIFT    = 4;   // 16 bytes per pixel
    localparam logic [4:0]  MAX_FRAMES_RST = 5'd16;
    localparam logic [39:0] MAX_BYTES_RST  = 40'd536870912;
    localparam logic [31:0] REV_MAX        = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== src/generation_tagged_frame_queue_core.sv =====
// Top level of the generation-tagged frame queue.
//
// A request is taken at every clock edge with start high (busy is always low), so one
// request per cycle is sustained. Its receipt appears on o_result with o_strobe high for
// exactly one cycle. The request and its frame byte cost (width*height*16) are registered
// on acceptance; the checks and the queue update run from that register, and their result
// is registered as the receipt. The receiver cannot stall, so receipts must be taken as
// they come. Frame descriptors sit in a FRAME_DEPTH-entry memory; the head entry is
// prefetched into a read register, so a dequeue finds it there without waiting on memory.
// No clearing pass follows reset. Write max_frames (offset 0x0) and max_bytes (offset
// 0x8) only while no request is in flight.
`default_nettype none

module generation_tagged_frame_queue_core
    import gtfq_pkg::*;
#(
    parameter int FRAME_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_req        i_req,
    output logic             o_strobe,
    output t_result          o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    t_cfg            cfg;
    t_entry          rd_entry;
    t_entry          wr_entry;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;

    // Every request completes in a single pass
    assign busy = 1'b0;

    gtfq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gtfq_store #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    gtfq_engine #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .AW          (AW)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start && !busy),
        .i_req      (i_req),
        .i_cfg      (cfg),
        .i_rd_entry (rd_entry),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_entry (wr_entry),
        .o_rd_addr  (rd_addr),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

// ===== src/gtfq_cfg.sv =====
// APB-style configuration registers: frame limit and byte budget.
`default_nettype none

module gtfq_cfg
    import gtfq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [4:0]  r_max_frames;
    logic [39:0] r_max_bytes;
    logic        wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;

    // Write the register selected by the address (8-byte stride)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frames <= MAX_FRAMES_RST;
            r_max_bytes  <= MAX_BYTES_RST;
        end else if (wr_fire) begin
            if (paddr[3]) begin
                r_max_bytes <= pwdata[39:0];
            end else begin
                r_max_frames <= pwdata[4:0];
            end
        end
    end

    // Read back
    assign prdata = paddr[3] ? {24'd0, r_max_bytes} : {59'd0, r_max_frames};

    assign o_cfg.max_frames = r_max_frames;
    assign o_cfg.max_bytes  = r_max_bytes;

endmodule

`default_nettype wire

// ===== src/gtfq_store.sv =====
// Frame descriptor memory with one write port and a registered read port.
`default_nettype none

module gtfq_store
    import gtfq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_entry,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_entry
);

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    // Write the tail entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    // Read the next head entry, passing a same-cycle write through
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd <= i_wr_entry;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd;

endmodule

`default_nettype wire

// ===== src/gtfq_engine.sv =====
// Request register, queue state, decision logic and receipt register.
`default_nettype none

module gtfq_engine
    import gtfq_pkg::*;
#(
    parameter int FRAME_DEPTH = 16,
    parameter int AW          = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_req          i_req,
    input  wire t_cfg          i_cfg,
    input  wire t_entry        i_rd_entry,
    output logic               o_wr_en,
    output logic    [AW-1:0]   o_wr_addr,
    output t_entry             o_wr_entry,
    output logic    [AW-1:0]   o_rd_addr,
    output logic               o_strobe,
    output t_result            o_result
);

    localparam int          CapInt   = (FRAME_DEPTH > 31) ? 31 : FRAME_DEPTH;
    localparam logic [4:0]  DEPTH_CAP = 5'(CapInt);
    localparam logic [AW-1:0] PTR_LAST = AW'(FRAME_DEPTH - 1);

    // Request stage
    logic               r_job_vld;
    t_req               r_req;
    logic [35:0]        r_fbytes;

    // Queue state
    logic [AW-1:0]      r_head,       n_head;
    logic [AW-1:0]      r_tail,       n_tail;
    logic [4:0]         r_count,      n_count;
    logic [39:0]        r_held,       n_held;
    logic [31:0]        r_gen,        n_gen;
    logic               r_accepting,  n_accepting;
    logic [31:0]        r_rev,        n_rev;
    logic               r_base_vld,   n_base_vld;
    logic [30:0]        r_base_num,   n_base_num;
    logic [30:0]        r_base_den,   n_base_den;
    logic               r_last_vld,   n_last_vld;
    logic signed [47:0] r_last,       n_last;

    // Receipt stage
    logic               r_res_vld;
    t_result            r_res;
    t_result            n_res;

    // Decision terms
    t_outcome           oc;
    t_reason            rs;
    t_error             ec;
    logic               deq_out;
    logic               rev_max;
    logic [4:0]         lim;
    logic [40:0]        byte_sum;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      tail_inc;
    logic [31:0]        frame_area;

    // Capture the request and its byte cost
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
        end else begin
            r_job_vld <= i_start;
        end
    end

    assign frame_area = 32'(i_req.frame_width) * 32'(i_req.frame_height);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req    <= i_req;
            r_fbytes <= {frame_area, 4'd0};
        end
    end

    assign rev_max  = (r_rev == REV_MAX);
    assign lim      = (i_cfg.max_frames > DEPTH_CAP) ? DEPTH_CAP : i_cfg.max_frames;
    assign byte_sum = {1'b0, r_held} + {5'd0, r_fbytes};
    assign head_inc = (r_head == PTR_LAST) ? '0 : r_head + AW'(1);
    assign tail_inc = (r_tail == PTR_LAST) ? '0 : r_tail + AW'(1);

    // Decide the request and the next queue state
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_held      = r_held;
        n_gen       = r_gen;
        n_accepting = r_accepting;
        n_rev       = r_rev;
        n_base_vld  = r_base_vld;
        n_base_num  = r_base_num;
        n_base_den  = r_base_den;
        n_last_vld  = r_last_vld;
        n_last      = r_last;
        oc          = OC_CHANGED;
        rs          = RS_NONE;
        ec          = EC_NONE;
        deq_out     = 1'b0;
        o_wr_en     = 1'b0;

        if (r_job_vld) begin
            if (r_req.generation == '0) begin
                oc = OC_ERROR;
                ec = EC_BAD_GEN;
            end else if (r_req.operation == OP_START) begin
                priority if (r_req.generation < r_gen) begin
                    oc = OC_ERROR;
                    ec = EC_BAD_GEN;
                end else if (r_req.generation == r_gen) begin
                    oc = r_accepting ? OC_NOOP : OC_CANCELLED;
                    rs = r_accepting ? RS_NONE : RS_GEN_CANCELLED;
                end else if (rev_max) begin
                    oc = OC_ERROR;
                    ec = EC_REV_OVERFLOW;
                end else begin
                    // Open the new generation on an empty queue
                    n_head      = '0;
                    n_tail      = '0;
                    n_count     = '0;
                    n_held      = '0;
                    n_base_vld  = 1'b0;
                    n_base_num  = '0;
                    n_base_den  = '0;
                    n_last_vld  = 1'b0;
                    n_last      = '0;
                    n_gen       = r_req.generation;
                    n_accepting = 1'b1;
                    n_rev       = r_rev + 32'd1;
                end
            end else if (r_req.generation != r_gen) begin
                oc = OC_STALE;
                rs = RS_STALE_GEN;
            end else begin
                unique case (r_req.operation)
                    OP_ENQUEUE: begin
                        priority if (!r_accepting) begin
                            oc = OC_CANCELLED;
                            rs = RS_GEN_CANCELLED;
                        end else if (r_req.cancel_requested) begin
                            oc = OC_CANCELLED;
                            rs = RS_OP_CANCELLED;
                        end else if (!r_req.has_timestamp) begin
                            oc = OC_ERROR;
                            ec = EC_NO_STAMP;
                        end else if (r_req.rate_num[31] || r_req.rate_num == '0 ||
                                     r_req.rate_den[31] || r_req.rate_den == '0) begin
                            oc = OC_ERROR;
                            ec = EC_BAD_BASE;
                        end else if (r_base_vld &&
                                     (r_req.rate_num[30:0] != r_base_num ||
                                      r_req.rate_den[30:0] != r_base_den)) begin
                            oc = OC_ERROR;
                            ec = EC_BASE_CHANGED;
                        end else if (r_last_vld && (r_req.timestamp <= r_last)) begin
                            oc = OC_ERROR;
                            ec = EC_STAMP_ORDER;
                        end else if (r_count >= lim) begin
                            oc = OC_REFUSED;
                            rs = RS_FRAME_CAP;
                        end else if (r_req.frame_width == '0 || r_req.frame_height == '0) begin
                            oc = OC_ERROR;
                            ec = EC_BAD_DIMS;
                        end else if (byte_sum > {1'b0, i_cfg.max_bytes}) begin
                            oc = OC_REFUSED;
                            rs = RS_BYTE_CAP;
                        end else if (rev_max) begin
                            oc = OC_ERROR;
                            ec = EC_REV_OVERFLOW;
                        end else begin
                            // Append the frame at the tail
                            o_wr_en    = 1'b1;
                            n_tail     = tail_inc;
                            n_count    = r_count + 5'd1;
                            n_held     = byte_sum[39:0];
                            n_base_vld = 1'b1;
                            n_base_num = r_req.rate_num[30:0];
                            n_base_den = r_req.rate_den[30:0];
                            n_last_vld = 1'b1;
                            n_last     = r_req.timestamp;
                            n_rev      = r_rev + 32'd1;
                        end
                    end
                    OP_DEQUEUE: begin
                        priority if (r_count == '0) begin
                            oc = r_accepting ? OC_NOOP : OC_CANCELLED;
                            rs = r_accepting ? RS_NONE : RS_GEN_CANCELLED;
                        end else if (rev_max) begin
                            oc = OC_ERROR;
                            ec = EC_REV_OVERFLOW;
                        end else begin
                            // Hand out the head frame
                            deq_out = 1'b1;
                            n_head  = head_inc;
                            n_count = r_count - 5'd1;
                            n_held  = ({4'd0, i_rd_entry.size} > r_held) ? '0 :
                                      r_held - {4'd0, i_rd_entry.size};
                            n_rev   = r_rev + 32'd1;
                        end
                    end
                    OP_CANCEL: begin
                        priority if (!r_accepting) begin
                            oc = OC_NOOP;
                            rs = RS_GEN_CANCELLED;
                        end else if (rev_max) begin
                            oc = OC_ERROR;
                            ec = EC_REV_OVERFLOW;
                        end else begin
                            // Drop the queue and stop accepting
                            n_head      = '0;
                            n_tail      = '0;
                            n_count     = '0;
                            n_held      = '0;
                            n_base_vld  = 1'b0;
                            n_base_num  = '0;
                            n_base_den  = '0;
                            n_last_vld  = 1'b0;
                            n_last      = '0;
                            n_accepting = 1'b0;
                            n_rev       = r_rev + 32'd1;
                            rs          = RS_GEN_CANCELLED;
                        end
                    end
                    default: begin
                        oc = OC_ERROR;
                        ec = EC_BAD_GEN;
                    end
                endcase
            end
        end
    end

    // Assemble the receipt
    always_comb begin
        n_res.outcome            = oc;
        n_res.reason             = rs;
        n_res.error_code         = ec;
        n_res.current_generation = n_gen;
        n_res.revision_now       = n_rev;
        n_res.frame_count        = n_count;
        n_res.byte_count         = n_held;
        n_res.frame_valid        = deq_out;
        n_res.frame_timestamp    = deq_out ? i_rd_entry.stamp : '0;
        n_res.frame_bytes        = deq_out ? i_rd_entry.size  : '0;
        n_res.out_rate_num       = deq_out ? r_base_num       : '0;
        n_res.out_rate_den       = deq_out ? r_base_den       : '0;
    end

    // Advance the queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_held      <= '0;
            r_gen       <= '0;
            r_accepting <= 1'b0;
            r_rev       <= '0;
            r_base_vld  <= 1'b0;
            r_base_num  <= '0;
            r_base_den  <= '0;
            r_last_vld  <= 1'b0;
            r_last      <= '0;
            r_res_vld   <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_held      <= n_held;
            r_gen       <= n_gen;
            r_accepting <= n_accepting;
            r_rev       <= n_rev;
            r_base_vld  <= n_base_vld;
            r_base_num  <= n_base_num;
            r_base_den  <= n_base_den;
            r_last_vld  <= n_last_vld;
            r_last      <= n_last;
            r_res_vld   <= r_job_vld;
        end
    end

    // Hold the receipt for its one strobe cycle
    always_ff @(posedge i_clk) begin
        if (r_job_vld) begin
            r_res <= n_res;
        end
    end

    assign o_wr_addr        = r_tail;
    assign o_wr_entry.stamp = r_req.timestamp;
    assign o_wr_entry.size  = r_fbytes;
    assign o_rd_addr        = n_head;
    assign o_strobe         = r_res_vld;
    assign o_result         = r_res;

endmodule

`default_nettype wire

// ===== src/gtfq_checker.sv =====
// Port-level checks of the frame queue, bound to the top level.
`default_nettype none

module gtfq_checker
    import gtfq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_strobe,
    input wire t_result     o_result
);

    // One receipt per accepted transaction, after the request and receipt registers
    a_one_receipt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, 2) && $past(i_rst_n) |-> o_strobe == $past(start && !busy, 2))
        else $error("receipt does not match accepted request");

    // An error receipt carries a code and no reason or frame
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.outcome == OC_ERROR |->
            o_result.reason == RS_NONE && o_result.error_code != EC_NONE &&
            !o_result.frame_valid)
        else $error("malformed error receipt");

    // A handed-out frame only comes with a change
    a_deq_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.frame_valid |-> o_result.outcome == OC_CHANGED)
        else $error("frame handed out without a change");

    // Revision advances by one on a change between back-to-back receipts
    a_rev_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(o_strobe) && o_result.outcome == OC_CHANGED |->
            o_result.revision_now == $past(o_result.revision_now) + 32'd1)
        else $error("revision did not advance on change");

    // Revision holds when nothing changed
    a_rev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(o_strobe) && o_result.outcome != OC_CHANGED |->
            o_result.revision_now == $past(o_result.revision_now))
        else $error("revision moved without a change");

endmodule

bind generation_tagged_frame_queue_core gtfq_checker u_gtfq_checker (.*);

`default_nettype wire

// ===== verif/tb_generation_tagged_frame_queue_core.sv =====
// Testbench of the frame queue core: directed and random requests against a shadow queue.
`timescale 1ns / 1ps

module tb_generation_tagged_frame_queue_core
    import gtfq_pkg::*;
();

    localparam int                 QUEUE_DEPTH    = 16;
    localparam int                 CYCLE_LIMIT    = 400000;
    localparam logic [3:0]         REG_MAX_FRAMES = 4'h0;
    localparam logic [3:0]         REG_MAX_BYTES  = 4'h8;
    localparam logic signed [47:0] STAMP_MIN      = 48'sh8000_0000_0000;
    localparam logic signed [47:0] STAMP_MAX      = 48'sh7FFF_FFFF_FFFF;
    localparam logic [39:0]        BUDGET_FULL    = 40'hFF_FFFF_FFFF;

    // Shadow copy of the queue: predicts each receipt and holds those not yet seen
    class frame_queue_shadow;
        logic signed [47:0] stamp_mem [QUEUE_DEPTH];
        logic        [35:0] size_mem [QUEUE_DEPTH];
        logic        [3:0]  head;
        logic        [3:0]  tail;
        logic        [4:0]  held;
        logic        [39:0] bytes_held;
        logic        [31:0] gen_now;
        logic        [31:0] revision;
        bit                 accepting;
        bit                 base_ok;
        bit                 last_ok;
        logic        [30:0] base_num;
        logic        [30:0] base_den;
        logic signed [47:0] last_stamp;
        logic        [4:0]  max_frames;
        logic        [39:0] max_bytes;
        t_result            awaited_receipts [$];
        int                 mismatches;

        function new();
            clear_queue();
            gen_now    = '0;
            revision   = '0;
            accepting  = 1'b0;
            max_frames = MAX_FRAMES_RST;
            max_bytes  = MAX_BYTES_RST;
            mismatches = 0;
        endfunction

        function void clear_queue();
            head       = '0;
            tail       = '0;
            held       = '0;
            bytes_held = '0;
            base_ok    = 1'b0;
            base_num   = '0;
            base_den   = '0;
            last_ok    = 1'b0;
            last_stamp = '0;
        endfunction

        function void apply_register(logic [3:0] addr, logic [63:0] data);
            if (addr == REG_MAX_FRAMES) begin
                max_frames = data[4:0];
            end else if (addr == REG_MAX_BYTES) begin
                max_bytes = data[39:0];
            end
        endfunction

        // Receipt carrying the counters as they stand now
        function t_result receipt(t_outcome oc, t_reason rs, t_error ec);
            t_result res;
            res                    = '0;
            res.outcome            = oc;
            res.reason             = rs;
            res.error_code         = ec;
            res.current_generation = gen_now;
            res.revision_now       = revision;
            res.frame_count        = held;
            res.byte_count         = bytes_held;
            return res;
        endfunction

        // Advance the shadow state by one request and return its receipt
        function t_result predict_receipt(t_req r);
            logic [63:0]        cost;
            logic [4:0]         lim;
            logic [35:0]        sz;
            logic signed [47:0] st;
            t_result            res;
            if (r.generation == '0) return receipt(OC_ERROR, RS_NONE, EC_BAD_GEN);
            if (r.operation == OP_START) begin
                if (r.generation < gen_now) return receipt(OC_ERROR, RS_NONE, EC_BAD_GEN);
                if (r.generation == gen_now) begin
                    return accepting ? receipt(OC_NOOP, RS_NONE, EC_NONE)
                                     : receipt(OC_CANCELLED, RS_GEN_CANCELLED, EC_NONE);
                end
                if (revision == REV_MAX) return receipt(OC_ERROR, RS_NONE, EC_REV_OVERFLOW);
                clear_queue();
                gen_now   = r.generation;
                accepting = 1'b1;
                revision++;
                return receipt(OC_CHANGED, RS_NONE, EC_NONE);
            end
            if (r.generation != gen_now) return receipt(OC_STALE, RS_STALE_GEN, EC_NONE);

            case (r.operation)
                OP_ENQUEUE: begin
                    lim = (max_frames > QUEUE_DEPTH) ? 5'(QUEUE_DEPTH) : max_frames;
                    if (!accepting) return receipt(OC_CANCELLED, RS_GEN_CANCELLED, EC_NONE);
                    if (r.cancel_requested) return receipt(OC_CANCELLED, RS_OP_CANCELLED, EC_NONE);
                    if (!r.has_timestamp) return receipt(OC_ERROR, RS_NONE, EC_NO_STAMP);
                    if (r.rate_num[31] || r.rate_num == '0 || r.rate_den[31] || r.rate_den == '0)
                        return receipt(OC_ERROR, RS_NONE, EC_BAD_BASE);
                    if (base_ok && (r.rate_num[30:0] != base_num || r.rate_den[30:0] != base_den))
                        return receipt(OC_ERROR, RS_NONE, EC_BASE_CHANGED);
                    if (last_ok && $signed(r.timestamp) <= $signed(last_stamp))
                        return receipt(OC_ERROR, RS_NONE, EC_STAMP_ORDER);
                    if (held >= lim) return receipt(OC_REFUSED, RS_FRAME_CAP, EC_NONE);
                    if (r.frame_width == '0 || r.frame_height == '0)
                        return receipt(OC_ERROR, RS_NONE, EC_BAD_DIMS);
                    cost = 64'(r.frame_width) * 64'(r.frame_height) * 64'd16;
                    if (64'(bytes_held) > 64'(max_bytes) ||
                        cost > 64'(max_bytes) - 64'(bytes_held))
                        return receipt(OC_REFUSED, RS_BYTE_CAP, EC_NONE);
                    if (revision == REV_MAX) return receipt(OC_ERROR, RS_NONE, EC_REV_OVERFLOW);
                    // push the frame and lock the time base
                    stamp_mem[tail] = r.timestamp;
                    size_mem[tail]  = cost[35:0];
                    tail++;
                    held++;
                    bytes_held = bytes_held + cost[39:0];
                    base_ok    = 1'b1;
                    base_num   = r.rate_num[30:0];
                    base_den   = r.rate_den[30:0];
                    last_ok    = 1'b1;
                    last_stamp = r.timestamp;
                    revision++;
                    return receipt(OC_CHANGED, RS_NONE, EC_NONE);
                end
                OP_DEQUEUE: begin
                    if (held == '0) begin
                        return accepting ? receipt(OC_NOOP, RS_NONE, EC_NONE)
                                         : receipt(OC_CANCELLED, RS_GEN_CANCELLED, EC_NONE);
                    end
                    if (revision == REV_MAX) return receipt(OC_ERROR, RS_NONE, EC_REV_OVERFLOW);
                    // pop the head frame
                    sz = size_mem[head];
                    st = stamp_mem[head];
                    head++;
                    held--;
                    bytes_held = (40'(sz) > bytes_held) ? 40'd0 : bytes_held - 40'(sz);
                    revision++;
                    res = receipt(OC_CHANGED, RS_NONE, EC_NONE);
                    res.frame_valid     = 1'b1;
                    res.frame_timestamp = st;
                    res.frame_bytes     = sz;
                    res.out_rate_num    = base_num;
                    res.out_rate_den    = base_den;
                    return res;
                end
                default: begin
                    if (!accepting) return receipt(OC_NOOP, RS_GEN_CANCELLED, EC_NONE);
                    if (revision == REV_MAX) return receipt(OC_ERROR, RS_NONE, EC_REV_OVERFLOW);
                    clear_queue();
                    accepting = 1'b0;
                    revision++;
                    return receipt(OC_CHANGED, RS_GEN_CANCELLED, EC_NONE);
                end
            endcase
        endfunction

        function void take_request(t_req r);
            awaited_receipts = {awaited_receipts, predict_receipt(r)};
        endfunction

        task report(string text);
            mismatches++;
            if (mismatches <= 40) $display("mismatch: %s", text);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // Compare one receipt with the oldest prediction
        task match_receipt(t_result got);
            t_result want;
            if (awaited_receipts.size() == 0) begin
                report($sformatf("receipt with none pending, outcome %0d", got.outcome));
                return;
            end
            want = awaited_receipts[0];
            awaited_receipts.delete(0);
            compare_field("outcome", got.outcome, want.outcome);
            compare_field("reason", got.reason, want.reason);
            compare_field("error_code", got.error_code, want.error_code);
            compare_field("current_generation", got.current_generation,
                          want.current_generation);
            compare_field("revision_now", got.revision_now, want.revision_now);
            compare_field("frame_count", got.frame_count, want.frame_count);
            compare_field("byte_count", got.byte_count, want.byte_count);
            compare_field("frame_valid", got.frame_valid, want.frame_valid);
            compare_field("frame_timestamp", got.frame_timestamp, want.frame_timestamp);
            compare_field("frame_bytes", got.frame_bytes, want.frame_bytes);
            compare_field("out_rate_num", got.out_rate_num, want.out_rate_num);
            compare_field("out_rate_den", got.out_rate_den, want.out_rate_den);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_req        i_req   = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    frame_queue_shadow board = new();
    int                cycle_count = 0;
    bit                steady = 1'b0;

    generation_tagged_frame_queue_core #(
        .FRAME_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Take each receipt in the cycle it is marked
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.match_receipt(o_result);
    end

    function automatic t_req noise_req();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return t_req'(raw[179:0]);
    endfunction

    function automatic t_req ctl_req(t_op op, logic [31:0] gen);
        t_req r;
        r = noise_req();
        r.operation  = op;
        r.generation = gen;
        return r;
    endfunction

    function automatic t_req frame_req(logic [31:0] gen, logic signed [47:0] ts,
                                       logic [31:0] num, logic [31:0] den,
                                       logic [15:0] w, logic [15:0] h);
        t_req r;
        r = '0;
        r.operation     = OP_ENQUEUE;
        r.generation    = gen;
        r.timestamp     = ts;
        r.has_timestamp = 1'b1;
        r.rate_num      = num;
        r.rate_den      = den;
        r.frame_width   = w;
        r.frame_height  = h;
        return r;
    endfunction

    // Enqueue well formed for the current generation; the limits or a cancelled generation may still turn it away
    function automatic t_req good_frame();
        t_req r;
        r = noise_req();
        r.operation        = OP_ENQUEUE;
        r.generation       = board.gen_now;
        r.has_timestamp    = 1'b1;
        r.cancel_requested = 1'b0;
        if (board.base_ok) begin
            r.rate_num = {1'b0, board.base_num};
            r.rate_den = {1'b0, board.base_den};
        end else if ($urandom_range(0, 7) == 0) begin
            r.rate_num = 32'h7FFF_FFFF;
            r.rate_den = 32'd1;
        end else begin
            r.rate_num = 32'($urandom_range(1, 32'h7FFF_FFFF));
            r.rate_den = 32'($urandom_range(1, 32'h7FFF_FFFF));
        end
        if (board.last_ok) r.timestamp = board.last_stamp + 48'($urandom_range(1, 5000));
        if ($urandom_range(0, 15) == 0) begin
            r.frame_width  = 16'($urandom_range(32768, 65535));
            r.frame_height = 16'($urandom_range(32768, 65535));
        end else begin
            r.frame_width  = 16'($urandom_range(1, 64));
            r.frame_height = 16'($urandom_range(1, 64));
        end
        return r;
    endfunction

    // Well-formed enqueue with one field altered to violate a check; the base and stamp checks only bite once locked
    function automatic t_req broken_frame();
        t_req r;
        r = good_frame();
        case ($urandom_range(0, 6))
            0: r.has_timestamp = 1'b0;
            1: r.rate_num = '0;
            2: r.rate_den = {1'b1, 31'($urandom)};
            3: r.rate_num = {1'b0, board.base_num ^ 31'd1};
            4: r.timestamp = board.last_stamp - 48'($urandom_range(0, 3));
            5: r.frame_width = '0;
            default: r.cancel_requested = 1'b1;
        endcase
        return r;
    endfunction

    function automatic t_req next_request();
        int   pick;
        t_req r;
        pick = $urandom_range(0, 99);
        if (pick < 48) return good_frame();
        if (pick < 72) return ctl_req(OP_DEQUEUE, board.gen_now);
        if (pick < 77) return ctl_req(OP_START, board.gen_now + 32'($urandom_range(1, 40)));
        if (pick < 80) return ctl_req(OP_CANCEL, board.gen_now);
        if (pick < 82) return ctl_req(OP_START, board.gen_now);
        if (pick < 92) return broken_frame();
        // noise: random fields, kept from pushing the generation far ahead
        r = noise_req();
        if ($urandom_range(0, 1) == 0) r.generation = board.gen_now;
        if (r.operation == OP_START) r.generation = 32'($urandom_range(0, board.gen_now));
        return r;
    endfunction

    // Present one request after a random gap and hold it until taken
    task automatic issue(input t_req r);
        int gap;
        if ($urandom_range(0, 39) == 0) steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        board.take_request(r);
    endtask

    // Drop start and drain every pending receipt
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.awaited_receipts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.apply_register(addr, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        t_req        r;
        logic [4:0]  frame_cap;
        logic [39:0] byte_cap;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: generation rules, the enqueue checks short of the frame and revision limits, drain and cancel
        issue(ctl_req(OP_START, 32'd0));
        issue(ctl_req(OP_DEQUEUE, 32'd7));
        issue(ctl_req(OP_START, 32'd7));
        issue(ctl_req(OP_START, 32'd7));
        issue(ctl_req(OP_START, 32'd3));
        issue(ctl_req(OP_DEQUEUE, 32'd7));
        r = frame_req(32'd7, 48'sd100, 32'd1, 32'd1, 16'd1, 16'd1);
        r.has_timestamp = 1'b0;
        issue(r);
        issue(frame_req(32'd7, 48'sd100, 32'd0, 32'd1, 16'd1, 16'd1));
        issue(frame_req(32'd7, 48'sd100, 32'd1, 32'h8000_0000, 16'd1, 16'd1));
        issue(frame_req(32'd7, 48'sd100, 32'd1, 32'd1, 16'd0, 16'd5));
        issue(frame_req(32'd7, STAMP_MIN, 32'h7FFF_FFFF, 32'd1, 16'hFFFF, 16'hFFFF));
        issue(frame_req(32'd7, STAMP_MIN, 32'h7FFF_FFFF, 32'd1, 16'd1, 16'd1));
        issue(frame_req(32'd7, 48'sd5, 32'h7FFF_FFFF, 32'd2, 16'd1, 16'd1));
        issue(frame_req(32'd7, STAMP_MIN, 32'h7FFF_FFFF, 32'd1, 16'd2, 16'd2));
        r = frame_req(32'd7, 48'sd5, 32'h7FFF_FFFF, 32'd1, 16'd1, 16'd1);
        r.cancel_requested = 1'b1;
        issue(r);
        issue(frame_req(32'd7, STAMP_MAX, 32'h7FFF_FFFF, 32'd1, 16'hFFFF, 16'd1));
        repeat (3) issue(ctl_req(OP_DEQUEUE, 32'd7));
        repeat (2) issue(ctl_req(OP_CANCEL, 32'd7));
        issue(frame_req(32'd7, 48'sd9, 32'd1, 32'd1, 16'd1, 16'd1));
        issue(ctl_req(OP_DEQUEUE, 32'd7));
        issue(ctl_req(OP_START, 32'd7));
        issue(ctl_req(OP_START, 32'd8));

        // Random phases, each under its own limits
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin frame_cap = 5'd16; byte_cap = BUDGET_FULL; end
                1: begin frame_cap = 5'd4;  byte_cap = 40'd300000; end
                2: begin frame_cap = 5'd31; byte_cap = 40'd1; end
                3: begin frame_cap = 5'd0;  byte_cap = 40'd1000000; end
                4: begin frame_cap = 5'd1;  byte_cap = BUDGET_FULL; end
                default: begin
                    frame_cap = 5'($urandom_range(1, 31));
                    byte_cap  = 40'($urandom_range(1, 1 << 22));
                end
            endcase
            settle();
            write_reg(REG_MAX_FRAMES, {32'($urandom), 27'($urandom), frame_cap});
            write_reg(REG_MAX_BYTES, {24'($urandom), byte_cap});
            repeat (170) issue(next_request());
        end

        // Top generation: no newer one exists after it
        issue(ctl_req(OP_START, 32'hFFFF_FFFF));
        issue(good_frame());
        issue(ctl_req(OP_DEQUEUE, 32'hFFFF_FFFF));
        issue(ctl_req(OP_START, 32'hFFFF_FFFF));

        settle();
        if (board.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/gtfq_pkg.sv
src/gtfq_cfg.sv
src/gtfq_store.sv
src/gtfq_engine.sv
src/generation_tagged_frame_queue_core.sv
src/gtfq_checker.sv
verif/tb_generation_tagged_frame_queue_core.sv
